// ===== rtl/linear_classifier_argmax_macros.svh =====
// Assertion helpers for the linear classifier block.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef LINEAR_CLASSIFIER_ARGMAX_MACROS_SVH
`define LINEAR_CLASSIFIER_ARGMAX_MACROS_SVH

// Same-cycle property.
`define LCA_CHECK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("linear_classifier_argmax: check failed");

// Antecedent this cycle, consequent next cycle.
`define LCA_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("linear_classifier_argmax: sequence check failed");

`endif

// ===== rtl/lca_pkg.sv =====
package lca_pkg;

  localparam int unsigned NUM_FEATURES = 20;
  localparam int unsigned CLASS_COUNT  = 4;

  localparam int unsigned INDEX_W    = 7;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned FEAT_W     = 16;
  localparam int unsigned CLASS_W    = 2;
  localparam int unsigned SCORE_W    = 40;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned BIAS_SHIFT = 14;

  typedef enum logic {
    OP_WEIGHT  = 1'b0,
    OP_FEATURE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        operation;
    logic [INDEX_W-1:0]         weight_index;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic signed [FEAT_W-1:0]   feature_value;
  } lca_in_t;

  typedef struct packed {
    logic [CLASS_W-1:0]        predicted_class;
    logic signed [SCORE_W-1:0] best_score;
  } lca_out_t;

endpackage

// ===== rtl/lca_ram.sv =====
module lca_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 20,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/linear_classifier_argmax.sv =====
// Linear multi-class classifier with argmax, streaming.
// Input channel (in_valid_i/in_ready_o/in_i): each beat is either a weight
// write (weight_index = class * (features + 1) + feature, last slot of a row
// is the bias) or one Q2.14 feature of the current vector. Features are
// consumed in order; the beat carrying the last feature of a vector closes it.
// Output channel (out_valid_o/out_ready_i/out_o): one beat per vector with the
// winning class (lowest index on ties) and its Q12.28 score including bias.
// Throughput: one input beat per cycle, weight writes and features alike,
// while in_ready_o is high. After the last feature beat is taken, the result
// is formed by RAM read, multiply, accumulate, bias add, then a registered
// compare tree, and is presented from the output register.
// Per-class weights live in one small RAM per class, read at the feature count,
// so all classes multiply-accumulate in parallel; biases sit in flops.
// Reset clears the feature count, accumulators and all valid flags; weights
// are not cleared and must be written before use.
// When the receiver stalls, one result waits in the output register and one
// more in a skid register; only a full skid drops in_ready_o and freezes the
// whole pipeline until the receiver takes a beat.
`include "linear_classifier_argmax_macros.svh"

module linear_classifier_argmax #(
  parameter int unsigned NumFeatures = lca_pkg::NUM_FEATURES,
  parameter int unsigned ClassCount  = lca_pkg::CLASS_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lca_pkg::lca_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lca_pkg::lca_out_t out_o
);

  import lca_pkg::*;

  localparam int unsigned PosW   = (NumFeatures > 1) ? $clog2(NumFeatures) : 1;
  localparam int unsigned RowLen = NumFeatures + 1;
  localparam int unsigned Lv     = $clog2(ClassCount);
  localparam int unsigned Leaves = 1 << Lv;
  localparam int unsigned Nodes  = 2 * Leaves - 1;
  localparam int unsigned ClsW   = Lv;

  logic en;
  logic in_fire, feat_fire, wr_fire, is_last;
  logic [PosW-1:0] pos_q;

  logic                     s1_valid_q, s1_last_q;
  logic signed [FEAT_W-1:0] s1_x_q;
  logic                     s2_valid_q, s2_last_q;
  logic                     s3_valid_q;
  logic [Lv:0]              tv_q;

  logic signed [SCORE_W-1:0] leaf_score [ClassCount];

  logic signed [SCORE_W-1:0] nd_score [Nodes];
  logic [ClsW-1:0]           nd_cls   [Nodes];
  logic                      nd_pres  [Nodes];

  logic            out_valid_q, skid_valid_q;
  lca_out_t        out_q, skid_q, res;
  logic            res_valid;
  logic [ClsW+1:0] cls_ext;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;
  assign in_fire    = in_valid_i && en;
  assign feat_fire  = in_fire && (in_i.operation == OP_FEATURE);
  assign wr_fire    = in_fire && (in_i.operation == OP_WEIGHT);
  assign is_last    = (pos_q == PosW'(NumFeatures - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (feat_fire) begin
      pos_q <= is_last ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_valid_q <= 1'b0;
      tv_q       <= '0;
    end else if (en) begin
      s1_valid_q <= feat_fire;
      s1_last_q  <= feat_fire && is_last;
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
      s3_valid_q <= s2_valid_q && s2_last_q;
      tv_q       <= {tv_q[Lv-1:0], s3_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (feat_fire) begin
      s1_x_q <= in_i.feature_value;
    end
  end

  // Per-class datapath: weight RAM, bias, multiply, accumulate, bias add.
  for (genvar c = 0; c < ClassCount; c++) begin : g_cls
    localparam int unsigned Base = c * RowLen;

    logic [31:0]                 idx_ext, off;
    logic                        hit, we_w, we_b;
    logic signed [WEIGHT_W-1:0]  w_rd, bias_q, s2_bias_q, s3_bias_q;
    logic signed [PROD_W-1:0]    prod, s2_prod_q;
    logic signed [SCORE_W-1:0]   acc_q, sum, s3_total_q, score, leaf_q;

    assign idx_ext = 32'(in_i.weight_index);
    assign hit     = (idx_ext >= 32'(Base)) && (idx_ext < 32'(Base + RowLen));
    assign off     = idx_ext - 32'(Base);
    assign we_b    = wr_fire && hit && (off == 32'(NumFeatures));
    assign we_w    = wr_fire && hit && (off != 32'(NumFeatures));

    lca_ram #(
      .Width (WEIGHT_W),
      .Depth (NumFeatures),
      .AddrW (PosW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we_w),
      .waddr_i (off[PosW-1:0]),
      .wdata_i (in_i.weight_value),
      .re_i    (feat_fire),
      .raddr_i (pos_q),
      .rdata_o (w_rd)
    );

    always_ff @(posedge clk_i) begin
      if (we_b) begin
        bias_q <= in_i.weight_value;
      end
    end

    assign prod  = PROD_W'(w_rd) * PROD_W'(s1_x_q);
    assign sum   = acc_q + SCORE_W'(s2_prod_q);
    assign score = s3_total_q + (SCORE_W'(s3_bias_q) <<< BIAS_SHIFT);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q <= '0;
      end else if (en && s2_valid_q) begin
        acc_q <= s2_last_q ? '0 : sum;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s2_prod_q <= prod;
        if (s1_last_q) begin
          s2_bias_q <= bias_q;
        end
        if (s2_valid_q && s2_last_q) begin
          s3_total_q <= sum;
          s3_bias_q  <= s2_bias_q;
        end
        if (s3_valid_q) begin
          leaf_q <= score;
        end
      end
    end

    assign leaf_score[c] = leaf_q;
  end

  // Leaves of the compare tree; padding leaves never win.
  for (genvar j = 0; j < Leaves; j++) begin : g_leaf
    if (j < ClassCount) begin : g_real
      assign nd_score[Leaves-1+j] = leaf_score[j];
      assign nd_pres[Leaves-1+j]  = 1'b1;
    end else begin : g_pad
      assign nd_score[Leaves-1+j] = '0;
      assign nd_pres[Leaves-1+j]  = 1'b0;
    end
    assign nd_cls[Leaves-1+j] = ClsW'(j);
  end

  // Registered argmax tree, each tree level registered; left (lower class) wins ties.
  for (genvar i = 0; i < Leaves - 1; i++) begin : g_node
    logic                      pick_r;
    logic signed [SCORE_W-1:0] sc_q;
    logic [ClsW-1:0]           cl_q;
    logic                      pr_q;

    assign pick_r = nd_pres[2*i+2] &&
                    (!nd_pres[2*i+1] || (nd_score[2*i+2] > nd_score[2*i+1]));

    always_ff @(posedge clk_i) begin
      if (en) begin
        sc_q <= pick_r ? nd_score[2*i+2] : nd_score[2*i+1];
        cl_q <= pick_r ? nd_cls[2*i+2] : nd_cls[2*i+1];
        pr_q <= nd_pres[2*i+1] || nd_pres[2*i+2];
      end
    end

    assign nd_score[i] = sc_q;
    assign nd_cls[i]   = cl_q;
    assign nd_pres[i]  = pr_q;
  end

  assign cls_ext             = {2'b00, nd_cls[0]};
  assign res.predicted_class = cls_ext[CLASS_W-1:0];
  assign res.best_score      = nd_score[0];
  assign res_valid           = en && tv_q[Lv];

  // Output register plus skid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `LCA_CHECK(a_skid_behind_out, skid_valid_q |-> out_valid_q)
  `LCA_CHECK(a_pos_in_range, pos_q <= PosW'(NumFeatures - 1))
  `LCA_CHECK_NEXT(a_last_tagged, feat_fire && is_last, s1_valid_q && s1_last_q)
  `LCA_CHECK_NEXT(a_stall_holds_root, skid_valid_q && tv_q[Lv], tv_q[Lv])

endmodule

// ===== dv/tb.sv =====
module tb;
  import lca_pkg::*;

  localparam int unsigned RowLen     = NUM_FEATURES + 1;
  localparam int unsigned StoreDepth = CLASS_COUNT * RowLen;

  class argmax_predictor;
    logic signed [WEIGHT_W-1:0] weights [StoreDepth];
    longint                     sums [CLASS_COUNT];
    int unsigned                position;
    lca_out_t                   pending_scores [$];
    int unsigned                mismatches;

    function new();
      foreach (weights[i]) weights[i] = '0;
      foreach (sums[i]) sums[i] = 0;
      position   = 0;
      mismatches = 0;
    endfunction

    function void take_beat(lca_in_t b);
      lca_out_t    winner;
      longint      score;
      longint      top;
      int unsigned top_class;
      if (b.operation == OP_WEIGHT) begin
        if (b.weight_index < StoreDepth) weights[b.weight_index] = b.weight_value;
        return;
      end
      for (int c = 0; c < CLASS_COUNT; c++) begin
        sums[c] += longint'(weights[c * RowLen + position]) * longint'(b.feature_value);
      end
      position++;
      if (position < NUM_FEATURES) return;
      top       = 0;
      top_class = 0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        score = sums[c] + longint'(weights[c * RowLen + NUM_FEATURES]) * (64'sd1 <<< BIAS_SHIFT);
        // strict compare: lower class keeps a tie
        if (c == 0 || score > top) begin
          top       = score;
          top_class = c;
        end
      end
      winner.predicted_class = top_class[CLASS_W-1:0];
      winner.best_score      = top[SCORE_W-1:0];
      pending_scores = {pending_scores, winner};
      foreach (sums[i]) sums[i] = 0;
      position = 0;
    endfunction

    function void match_result(lca_out_t r);
      lca_out_t want;
      if (pending_scores.size() == 0) begin
        $display("%0t: result with none pending: class %0d score %0d",
                 $time, r.predicted_class, r.best_score);
        mismatches++;
        return;
      end
      want = pending_scores.pop_front();
      if (r.predicted_class !== want.predicted_class) begin
        $display("%0t: predicted_class expected %0d actual %0d",
                 $time, want.predicted_class, r.predicted_class);
        mismatches++;
      end
      if (r.best_score !== want.best_score) begin
        $display("%0t: best_score expected %0d actual %0d",
                 $time, want.best_score, r.best_score);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  lca_in_t  in_i        = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  lca_out_t out_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned features_sent  = 0;

  argmax_predictor scorer = new();

  linear_classifier_argmax dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) scorer.take_beat(in_i);
      if (out_valid_o && out_ready_i) scorer.match_result(out_o);
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(lca_in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (b.operation == OP_FEATURE) features_sent = (features_sent + 1) % NUM_FEATURES;
  endtask

  task automatic write_weight(int unsigned idx, logic [WEIGHT_W-1:0] val);
    lca_in_t b;
    b.operation     = OP_WEIGHT;
    b.weight_index  = idx[INDEX_W-1:0];
    b.weight_value  = val;
    b.feature_value = FEAT_W'($urandom());
    send_beat(b);
  endtask

  task automatic send_feature(logic [FEAT_W-1:0] val);
    lca_in_t b;
    b.operation     = OP_FEATURE;
    b.weight_index  = INDEX_W'($urandom());
    b.weight_value  = WEIGHT_W'($urandom());
    b.feature_value = val;
    send_beat(b);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(32)) - 16'd16;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic load_weights();
    for (int unsigned i = 0; i < StoreDepth; i++) write_weight(i, pick_word());
  endtask

  // counted is low for a beat the block ignores
  task automatic random_beat(output bit counted);
    int unsigned k;
    int unsigned cls;
    k       = $urandom_range(99);
    cls     = $urandom_range(CLASS_COUNT - 1);
    counted = 1'b1;
    if (k < 84) begin
      send_feature(pick_word());
    end else if (k < 91) begin
      write_weight($urandom_range(StoreDepth - 1), pick_word());
    end else if (k < 96) begin
      // slot read by the very next feature or by the closing bias add
      write_weight(cls * RowLen + ($urandom_range(1) ? features_sent : NUM_FEATURES),
                   pick_word());
    end else begin
      write_weight($urandom_range(2 ** INDEX_W - 1, StoreDepth), pick_word());
      counted = 1'b0;
    end
  endtask

  initial begin
    int unsigned done;
    bit          counted;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero weights; classes 1 and 3 share the top bias, so they tie
    for (int unsigned i = 0; i < StoreDepth; i++) begin
      if (i % RowLen == NUM_FEATURES)
        write_weight(i, ((i / RowLen) % 2) ? 16'h7fff : 16'h8000);
      else
        write_weight(i, 16'h0000);
    end

    for (int unsigned f = 0; f < NUM_FEATURES; f++) begin
      if (f == 10) begin
        write_weight(1 * RowLen + 10, 16'h7fff);
        write_weight(3 * RowLen + 10, 16'h7fff);
        write_weight(2 ** INDEX_W - 1, 16'h8000);
        write_weight(StoreDepth, 16'h7fff);
        send_feature(16'h8000);
      end else begin
        case (f % 4)
          0:       send_feature(16'h8000);
          1:       send_feature(16'h7fff);
          2:       send_feature(16'h0000);
          default: send_feature(16'hffff);
        endcase
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      load_weights();
      done = 0;
      while (done < 170) begin
        random_beat(counted);
        if (counted) done++;
      end
    end

    in_valid_i <= 1'b0;
    while (scorer.pending_scores.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (scorer.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== linear_classifier_argmax.f =====
+incdir+rtl
rtl/lca_pkg.sv
rtl/lca_ram.sv
rtl/linear_classifier_argmax.sv
dv/tb.sv
